FILE: hw/rtl/kdve_pkg.sv
package kdve_pkg;

    localparam int INTEGER_BITS_DEFAULT        = 32;
    localparam int MAX_FRACTION_DIGITS_DEFAULT = 9;

    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int INT_OUT_W   = 32;
    localparam int FRAC_W      = 30;
    localparam int COUNT_OUT_W = 4;
    localparam int MATCH_W     = 3;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0b;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0c;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [BYTE_W-1:0] CH_POINT = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3a;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_BLANKS,
        PH_COLON,
        PH_LEADWS,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND,
        ST_NO_WORD,
        ST_NO_POINT,
        ST_NEGATIVE
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_buffer;
    } t_item;

    typedef struct packed {
        t_status                 status;
        logic [INT_OUT_W-1:0]    integer_part;
        logic [FRAC_W-1:0]       fraction_value;
        logic [COUNT_OUT_W-1:0]  fraction_digit_count;
        logic                    fraction_truncated;
    } t_result;

    // Characters of the word "bogomips".
    function automatic logic [BYTE_W-1:0] keyword_char(input logic [MATCH_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h6f;
            3'd2:    ch = 8'h67;
            3'd3:    ch = 8'h6f;
            3'd4:    ch = 8'h6d;
            3'd5:    ch = 8'h69;
            3'd6:    ch = 8'h70;
            3'd7:    ch = 8'h73;
            default: ch = 8'h62;
        endcase
        return ch;
    endfunction

endpackage

FILE: hw/rtl/kdve_in_if.sv
interface kdve_in_if;
    logic                          valid;
    logic                          ready;
    logic [kdve_pkg::BYTE_W-1:0]   text_byte;
    logic                          end_of_buffer;

    modport source (output valid, output text_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input text_byte, input end_of_buffer, output ready);
endinterface

FILE: hw/rtl/kdve_out_if.sv
interface kdve_out_if;
    logic                               valid;
    logic                               ready;
    logic [kdve_pkg::STATUS_W-1:0]      status;
    logic [kdve_pkg::INT_OUT_W-1:0]     integer_part;
    logic [kdve_pkg::FRAC_W-1:0]        fraction_value;
    logic [kdve_pkg::COUNT_OUT_W-1:0]   fraction_digit_count;
    logic                               fraction_truncated;

    modport source (
        output valid, output status, output integer_part, output fraction_value,
        output fraction_digit_count, output fraction_truncated, input ready
    );
    modport sink (
        input valid, input status, input integer_part, input fraction_value,
        input fraction_digit_count, input fraction_truncated, output ready
    );
endinterface

FILE: hw/rtl/kdve_in_stage.sv
module kdve_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    kdve_in_if.sink         i_in,
    input  logic            i_take,
    output logic            o_valid,
    output kdve_pkg::t_item o_item
);

    logic            r_valid;
    kdve_pkg::t_item r_item;

    // The stage refills in the same cycle that the parser takes its beat.
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.text_byte     <= i_in.text_byte;
            r_item.end_of_buffer <= i_in.end_of_buffer;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hw/rtl/kdve_parser.sv
module kdve_parser #(
    parameter int INTEGER_BITS        = kdve_pkg::INTEGER_BITS_DEFAULT,
    parameter int MAX_FRACTION_DIGITS = kdve_pkg::MAX_FRACTION_DIGITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  kdve_pkg::t_item   i_item,
    output logic              o_emit,
    output kdve_pkg::t_result o_result
);

    localparam int IW = INTEGER_BITS + 4;
    localparam int CW = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int FW = kdve_pkg::FRAC_W;
    localparam int MW = kdve_pkg::MATCH_W;

    function automatic logic is_space(input logic [kdve_pkg::BYTE_W-1:0] c);
        return c == kdve_pkg::CH_SPACE || c == kdve_pkg::CH_TAB || c == kdve_pkg::CH_LF ||
               c == kdve_pkg::CH_VT || c == kdve_pkg::CH_FF || c == kdve_pkg::CH_CR;
    endfunction

    function automatic logic is_digit(input logic [kdve_pkg::BYTE_W-1:0] c);
        return c >= kdve_pkg::CH_ZERO && c <= kdve_pkg::CH_NINE;
    endfunction

    kdve_pkg::t_phase         r_phase, n_phase, w_phase;
    logic [MW-1:0]            r_match, n_match, w_match;
    logic [INTEGER_BITS-1:0]  r_int_acc, n_int_acc, w_int_acc;
    logic [FW-1:0]            r_frac_acc, n_frac_acc, w_frac_acc;
    logic [CW-1:0]            r_frac_cnt, n_frac_cnt, w_frac_cnt;
    logic                     r_negative, n_negative, w_negative;
    logic                     r_truncated, n_truncated, w_truncated;

    logic [kdve_pkg::BYTE_W-1:0] w_c;
    logic                        w_last;
    logic [3:0]                  w_digit;
    logic [IW-1:0]               w_int_mul;
    logic [INTEGER_BITS-1:0]     w_int_next;
    logic [FW-1:0]               w_frac_next;
    logic [MW-1:0]               w_restart;
    logic                        w_take_emit;
    logic                        w_emit;
    kdve_pkg::t_status           w_code;
    kdve_pkg::t_status           w_status;

    assign w_c     = i_item.text_byte;
    assign w_last  = i_item.end_of_buffer;
    assign w_digit = 4'(w_c - kdve_pkg::CH_ZERO);

    // Multiply by ten with saturation: any carry above the integer width saturates.
    assign w_int_mul  = (IW'(r_int_acc) << 3) + (IW'(r_int_acc) << 1) + IW'(w_digit);
    assign w_int_next = (w_int_mul[IW-1:INTEGER_BITS] != '0) ? '1
                                                             : w_int_mul[INTEGER_BITS-1:0];
    // The fraction accumulator is only FRAC_W bits wide, the width of the output field, so it wraps there.
    assign w_frac_next = (r_frac_acc << 3) + (r_frac_acc << 1) + FW'(w_digit);
    assign w_restart   = (w_c == kdve_pkg::keyword_char('0)) ? MW'(1) : '0;

    // Effect of the byte itself on the parse state.
    always_comb begin
        w_phase     = r_phase;
        w_match     = r_match;
        w_int_acc   = r_int_acc;
        w_frac_acc  = r_frac_acc;
        w_frac_cnt  = r_frac_cnt;
        w_negative  = r_negative;
        w_truncated = r_truncated;
        w_take_emit = 1'b0;
        if (w_c != kdve_pkg::CH_NUL) begin
            case (r_phase)
                kdve_pkg::PH_SEARCH: begin
                    if (w_c == kdve_pkg::keyword_char(r_match)) begin
                        if (r_match == MW'(7)) begin
                            w_match = '0;
                            w_phase = kdve_pkg::PH_BLANKS;
                        end else begin
                            w_match = r_match + MW'(1);
                        end
                    end else begin
                        w_match = w_restart;
                    end
                end
                kdve_pkg::PH_BLANKS: begin
                    if (w_c == kdve_pkg::CH_COLON) begin
                        w_phase = kdve_pkg::PH_COLON;
                    end else if (w_c != kdve_pkg::CH_SPACE && w_c != kdve_pkg::CH_TAB) begin
                        w_phase = kdve_pkg::PH_SEARCH;
                        w_match = w_restart;
                    end
                end
                kdve_pkg::PH_COLON, kdve_pkg::PH_LEADWS: begin
                    if (is_space(w_c)) begin
                        w_phase = kdve_pkg::PH_LEADWS;
                    end else if (w_c == kdve_pkg::CH_PLUS || w_c == kdve_pkg::CH_MINUS) begin
                        w_negative = (w_c == kdve_pkg::CH_MINUS);
                        w_phase    = kdve_pkg::PH_SIGN;
                    end else if (is_digit(w_c)) begin
                        w_int_acc = w_int_next;
                        w_phase   = kdve_pkg::PH_INT;
                    end else if (w_c == kdve_pkg::CH_POINT && r_phase == kdve_pkg::PH_COLON) begin
                        w_phase = kdve_pkg::PH_FRAC;
                    end else begin
                        w_take_emit = 1'b1;
                    end
                end
                kdve_pkg::PH_SIGN: begin
                    if (is_digit(w_c)) begin
                        w_int_acc = w_int_next;
                        w_phase   = kdve_pkg::PH_INT;
                    end else begin
                        w_take_emit = 1'b1;
                    end
                end
                kdve_pkg::PH_INT: begin
                    if (is_digit(w_c)) begin
                        w_int_acc = w_int_next;
                    end else if (w_c == kdve_pkg::CH_POINT) begin
                        w_phase = kdve_pkg::PH_FRAC;
                    end else begin
                        w_take_emit = 1'b1;
                    end
                end
                kdve_pkg::PH_FRAC: begin
                    if (is_digit(w_c)) begin
                        if (r_frac_cnt < CW'(MAX_FRACTION_DIGITS)) begin
                            w_frac_acc = w_frac_next;
                            w_frac_cnt = r_frac_cnt + CW'(1);
                        end else begin
                            w_truncated = 1'b1;
                        end
                    end else begin
                        w_take_emit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result: either the byte ends the number, or the text ends here.
    always_comb begin
        w_emit = 1'b0;
        w_code = kdve_pkg::ST_NO_POINT;
        if (w_take_emit) begin
            w_emit = 1'b1;
            w_code = (r_phase == kdve_pkg::PH_FRAC) ? kdve_pkg::ST_FOUND
                                                    : kdve_pkg::ST_NO_POINT;
        end else if (w_c == kdve_pkg::CH_NUL || w_last) begin
            case (w_phase)
                kdve_pkg::PH_SEARCH, kdve_pkg::PH_BLANKS: begin
                    w_emit = 1'b1;
                    w_code = kdve_pkg::ST_NO_WORD;
                end
                kdve_pkg::PH_FRAC: begin
                    w_emit = 1'b1;
                    w_code = kdve_pkg::ST_FOUND;
                end
                kdve_pkg::PH_DONE: begin
                    w_emit = 1'b0;
                end
                default: begin
                    w_emit = 1'b1;
                    w_code = kdve_pkg::ST_NO_POINT;
                end
            endcase
        end

        w_status = w_code;
        if (w_code == kdve_pkg::ST_FOUND && w_negative && w_int_acc != '0) begin
            w_status = kdve_pkg::ST_NEGATIVE;
        end

        o_emit          = w_emit;
        o_result.status = w_status;
        if (w_status == kdve_pkg::ST_FOUND) begin
            o_result.integer_part         = kdve_pkg::INT_OUT_W'(w_int_acc);
            o_result.fraction_value       = w_frac_acc;
            o_result.fraction_digit_count = kdve_pkg::COUNT_OUT_W'(w_frac_cnt);
            o_result.fraction_truncated   = w_truncated;
        end else begin
            o_result.integer_part         = '0;
            o_result.fraction_value       = '0;
            o_result.fraction_digit_count = '0;
            o_result.fraction_truncated   = 1'b0;
        end
    end

    // Next state: an emitted result parks the parser in PH_DONE; the last byte of a buffer returns everything to reset.
    always_comb begin
        n_phase     = w_emit ? kdve_pkg::PH_DONE : w_phase;
        n_match     = w_match;
        n_int_acc   = w_int_acc;
        n_frac_acc  = w_frac_acc;
        n_frac_cnt  = w_frac_cnt;
        n_negative  = w_negative;
        n_truncated = w_truncated;
        if (w_last) begin
            n_phase     = kdve_pkg::PH_SEARCH;
            n_match     = '0;
            n_int_acc   = '0;
            n_frac_acc  = '0;
            n_frac_cnt  = '0;
            n_negative  = 1'b0;
            n_truncated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= kdve_pkg::PH_SEARCH;
            r_match     <= '0;
            r_int_acc   <= '0;
            r_frac_acc  <= '0;
            r_frac_cnt  <= '0;
            r_negative  <= 1'b0;
            r_truncated <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_match     <= n_match;
            r_int_acc   <= n_int_acc;
            r_frac_acc  <= n_frac_acc;
            r_frac_cnt  <= n_frac_cnt;
            r_negative  <= n_negative;
            r_truncated <= n_truncated;
        end
    end

endmodule

FILE: hw/rtl/kdve_out_reg.sv
module kdve_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  kdve_pkg::t_result i_result,
    output logic              o_space,
    kdve_out_if.source        o_out
);

    logic              r_valid;
    kdve_pkg::t_result r_result;

    // A new result may enter in the cycle that the held one leaves.
    assign o_space = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid                = r_valid;
    assign o_out.status               = r_result.status;
    assign o_out.integer_part         = r_result.integer_part;
    assign o_out.fraction_value       = r_result.fraction_value;
    assign o_out.fraction_digit_count = r_result.fraction_digit_count;
    assign o_out.fraction_truncated   = r_result.fraction_truncated;

endmodule

FILE: hw/rtl/keyword_decimal_value_extractor.sv
// Scans a text buffer for the word "bogomips" followed by optional blanks, a colon
// and a decimal number, and returns that number as integer part, fraction digits
// and digit count, or a status code when no usable value is found.
// Input channel i_in: one text byte per beat, end_of_buffer marks the last byte.
// Output channel o_out: at most one result beat per buffer.
// Throughput is one byte per cycle while results are taken; the parse state is updated once per byte by a
// single level of logic around a multiply by ten built from shifts and adds.
// The beat that causes a result is first registered in the input register; the result is
// then registered in the result register, which drives o_out.
// While the receiver stalls, one more byte is taken into the input register;
// further bytes are held off until the waiting result is taken.
// A byte with end_of_buffer set returns the parser to its reset state, so the next
// beat starts a new buffer. Reset is synchronous; it empties both registers and
// puts the parser into the keyword search.
module keyword_decimal_value_extractor #(
    parameter int INTEGER_BITS        = kdve_pkg::INTEGER_BITS_DEFAULT,
    parameter int MAX_FRACTION_DIGITS = kdve_pkg::MAX_FRACTION_DIGITS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kdve_in_if.sink    i_in,
    kdve_out_if.source o_out
);

    logic              w_in_valid;
    kdve_pkg::t_item   w_item;
    logic              w_space;
    logic              w_take;
    logic              w_emit;
    kdve_pkg::t_result w_result;

    assign w_take = w_in_valid && w_space;

    kdve_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    kdve_parser #(
        .INTEGER_BITS        (INTEGER_BITS),
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_take),
        .i_item   (w_item),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    kdve_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take && w_emit),
        .i_result (w_result),
        .o_space  (w_space),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    a_value_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != kdve_pkg::ST_FOUND |->
            o_out.integer_part == '0 && o_out.fraction_value == '0 &&
            o_out.fraction_digit_count == '0 && !o_out.fraction_truncated)
        else $error("value fields set on a result without a value");

    a_truncated_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.fraction_truncated |->
            o_out.fraction_digit_count == kdve_pkg::COUNT_OUT_W'(MAX_FRACTION_DIGITS))
        else $error("fraction truncated before the digit limit was reached");

    a_result_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_in_valid))
        else $error("result appeared without a byte in the input register");
`endif

endmodule
